### hdl/ccpq_pkg.sv
package ccpq_pkg;

   localparam int TIME_W = 31;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;

   localparam logic [1:0] OP_HDR  = 2'd0;
   localparam logic [1:0] OP_DATA = 2'd1;
   localparam logic [1:0] OP_TRL  = 2'd2;
   localparam logic [1:0] OP_DEQ  = 2'd3;

   localparam logic [2:0] KIND_HDR     = 3'd0;
   localparam logic [2:0] KIND_DATA    = 3'd1;
   localparam logic [2:0] KIND_TRL     = 3'd2;
   localparam logic [2:0] KIND_EMPTY   = 3'd3;
   localparam logic [2:0] KIND_VERDICT = 3'd4;

   localparam logic [1:0] VERD_OK      = 2'd0;
   localparam logic [1:0] VERD_BAD_SUM = 2'd1;
   localparam logic [1:0] VERD_FULL    = 2'd2;
   localparam logic [1:0] VERD_LEN_ERR = 2'd3;

   localparam logic [LEN_W-1:0] BYTES_SAT = '1;

   // request word, last field in the low bits
   typedef struct packed {
      logic [1:0]        pad;
      logic              dequeue_queue;
      logic [BYTE_W-1:0] check_byte;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0] priority_req;
      logic [BYTE_W-1:0] src_addr;
      logic [BYTE_W-1:0] dest_addr;
      logic [TIME_W-1:0] arrival_time;
   } req_data_type;

   // response word, last field in the low bits
   typedef struct packed {
      logic              pad;
      logic [1:0]        verdict;
      logic [BYTE_W-1:0] out_byte;
      logic [LEN_W-1:0]  out_len;
      logic [BYTE_W-1:0] out_priority;
      logic [BYTE_W-1:0] out_src;
      logic [BYTE_W-1:0] out_dest;
      logic [TIME_W-1:0] out_time;
   } rsp_data_type;

   // one stored packet header
   typedef struct packed {
      logic [TIME_W-1:0] arrival_time;
      logic [BYTE_W-1:0] dest_addr;
      logic [BYTE_W-1:0] src_addr;
      logic [BYTE_W-1:0] priority_req;
      logic [LEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0] check_byte;
   } hdr_entry_type;

endpackage

### hdl/ccpq_ram.sv
module ccpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/checksum_checked_priority_queues_top.sv
// Two-priority packet FIFO with XOR checksum check. Packets arrive as a header
// word, one word per data byte and a checksum trailer; a good packet is stored
// in queue 0 (priority zero) or queue 1, and every trailer that follows a
// header answers with one verdict word. A dequeue word streams the oldest
// packet of the named queue as a header word, one word per payload byte and a
// trailer word, or answers with one queue-empty word. Header and data words
// are taken one per cycle while the block is idle. Bytes are gathered in a
// staging area of the payload RAM; an accepted packet is then copied into its
// queue slot, one RAM read and one RAM write per byte, before its verdict.
// A dequeue reads the payload RAM once per payload byte word. The RAMs need
// no clearing after reset. rsp_tlast marks the last response word caused by
// one request word.
module checksum_checked_priority_queues_top
   import ccpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_LEN     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // arrival_time, dest_addr, src_addr, priority_req, payload_len,
   // data_byte, check_byte, dequeue_queue, zero fill
   input  logic [79:0] req_tdata,
   // opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_time, out_dest, out_src, out_priority, out_len, out_byte, verdict,
   // zero fill
   output logic [71:0] rsp_tdata,
   // result_kind
   output logic [2:0]  rsp_tuser,
   // last_of_run
   output logic        rsp_tlast
);

   localparam int SLOTS    = 2 * QUEUE_DEPTH;
   localparam int SW       = $clog2(SLOTS);
   localparam int IW       = $clog2(QUEUE_DEPTH);
   localparam int CW       = $clog2(QUEUE_DEPTH + 1);
   localparam int PDEPTH   = (SLOTS + 1) * MAX_LEN;
   localparam int PW       = $clog2(PDEPTH);
   localparam int STG_BASE = SLOTS * MAX_LEN;
   localparam int HDR_W    = $bits(hdr_entry_type);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_COPY    = 3'd1;
   localparam logic [2:0] S_VERD    = 3'd2;
   localparam logic [2:0] S_EMPTY   = 3'd3;
   localparam logic [2:0] S_DQ_HDR  = 3'd4;
   localparam logic [2:0] S_DQ_BYTE = 3'd5;
   localparam logic [2:0] S_DQ_TRL  = 3'd6;

   function automatic logic [SW-1:0] slot_of(input logic q, input logic [IW-1:0] idx);
      slot_of = q ? (SW'(QUEUE_DEPTH) + SW'(idx)) : SW'(idx);
   endfunction

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
      next_idx = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [IW-1:0]     head_ff [2];
   logic [IW-1:0]     head_in [2];
   logic [IW-1:0]     tail_ff [2];
   logic [IW-1:0]     tail_in [2];
   logic [CW-1:0]     count_ff [2];
   logic [CW-1:0]     count_in [2];
   logic              assembling_ff, assembling_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [LEN_W-1:0]  bytes_ff, bytes_in;
   logic [TIME_W-1:0] stg_time_ff, stg_time_in;
   logic [BYTE_W-1:0] stg_dest_ff, stg_dest_in;
   logic [BYTE_W-1:0] stg_src_ff, stg_src_in;
   logic [BYTE_W-1:0] stg_prio_ff, stg_prio_in;
   logic [LEN_W-1:0]  stg_len_ff, stg_len_in;
   logic [1:0]        verdict_ff, verdict_in;
   logic [PW-1:0]     base_ff, base_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic              copy_wr_ff, copy_wr_in;
   logic [LEN_W-1:0]  copy_wr_idx_ff, copy_wr_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   logic              hdr_wr_en, hdr_rd_en;
   logic [SW-1:0]     hdr_wr_addr, hdr_rd_addr;
   hdr_entry_type     hdr_wr_data, hdr_rd_data;
   logic [HDR_W-1:0]  hdr_rd_raw;
   logic              pay_wr_en, pay_rd_en;
   logic [PW-1:0]     pay_wr_addr, pay_rd_addr;
   logic [BYTE_W-1:0] pay_wr_data, pay_rd_data;

   req_data_type      req_d;
   logic              accept;
   logic              out_free;
   logic              enq_q;
   logic              deq_q;
   logic [SW-1:0]     enq_slot, deq_slot;
   logic [1:0]        trl_verdict;

   assign req_d      = req_data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign enq_q      = (stg_prio_ff != '0);
   assign deq_q      = req_d.dequeue_queue;
   assign enq_slot   = slot_of(enq_q, tail_ff[enq_q]);
   assign deq_slot   = slot_of(deq_q, head_ff[deq_q]);
   assign hdr_rd_data = hdr_entry_type'(hdr_rd_raw);

   always_comb begin
      if (stg_len_ff > LEN_W'(MAX_LEN) || bytes_ff != stg_len_ff) begin
         trl_verdict = VERD_LEN_ERR;
      end else if (xor_ff != req_d.check_byte) begin
         trl_verdict = VERD_BAD_SUM;
      end else if (count_ff[enq_q] == CW'(QUEUE_DEPTH)) begin
         trl_verdict = VERD_FULL;
      end else begin
         trl_verdict = VERD_OK;
      end
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      assembling_in  = assembling_ff;
      xor_in         = xor_ff;
      bytes_in       = bytes_ff;
      stg_time_in    = stg_time_ff;
      stg_dest_in    = stg_dest_ff;
      stg_src_in     = stg_src_ff;
      stg_prio_in    = stg_prio_ff;
      stg_len_in     = stg_len_ff;
      verdict_in     = verdict_ff;
      base_in        = base_ff;
      idx_in         = idx_ff;
      len_in         = len_ff;
      chk_in         = chk_ff;
      copy_wr_in     = 1'b0;
      copy_wr_idx_in = copy_wr_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_data_in    = rsp_data_ff;

      hdr_wr_en   = 1'b0;
      hdr_wr_addr = enq_slot;
      hdr_wr_data = '{arrival_time: stg_time_ff, dest_addr: stg_dest_ff,
                      src_addr: stg_src_ff, priority_req: stg_prio_ff,
                      payload_len: stg_len_ff, check_byte: req_d.check_byte};
      hdr_rd_en   = 1'b0;
      hdr_rd_addr = deq_slot;
      pay_rd_en   = 1'b0;
      pay_rd_addr = base_ff + PW'(idx_ff);

      // staged byte lands in its queue slot in the cycle after its read
      pay_wr_en   = copy_wr_ff;
      pay_wr_addr = base_ff + PW'(copy_wr_idx_ff);
      pay_wr_data = pay_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  OP_HDR: begin
                     stg_time_in   = req_d.arrival_time;
                     stg_dest_in   = req_d.dest_addr;
                     stg_src_in    = req_d.src_addr;
                     stg_prio_in   = req_d.priority_req;
                     stg_len_in    = req_d.payload_len;
                     xor_in        = req_d.dest_addr ^ req_d.src_addr ^ req_d.priority_req
                                     ^ BYTE_W'(req_d.payload_len);
                     bytes_in      = '0;
                     assembling_in = 1'b1;
                  end
                  OP_DATA: begin
                     if (assembling_ff) begin
                        if (bytes_ff < LEN_W'(MAX_LEN)) begin
                           pay_wr_en   = 1'b1;
                           pay_wr_addr = PW'(STG_BASE) + PW'(bytes_ff);
                           pay_wr_data = req_d.data_byte;
                        end
                        xor_in = xor_ff ^ req_d.data_byte;
                        if (bytes_ff != BYTES_SAT) begin
                           bytes_in = bytes_ff + 1'b1;
                        end
                     end
                  end
                  OP_TRL: begin
                     if (assembling_ff) begin
                        assembling_in = 1'b0;
                        verdict_in    = trl_verdict;
                        state_in      = S_VERD;
                        if (trl_verdict == VERD_OK) begin
                           hdr_wr_en       = 1'b1;
                           tail_in[enq_q]  = next_idx(tail_ff[enq_q]);
                           count_in[enq_q] = count_ff[enq_q] + 1'b1;
                           base_in         = PW'(enq_slot) * PW'(MAX_LEN);
                           idx_in          = '0;
                           if (stg_len_ff != '0) begin
                              state_in = S_COPY;
                           end
                        end
                     end
                  end
                  OP_DEQ: begin
                     if (count_ff[deq_q] == '0) begin
                        state_in = S_EMPTY;
                     end else begin
                        hdr_rd_en       = 1'b1;
                        base_in         = PW'(deq_slot) * PW'(MAX_LEN);
                        head_in[deq_q]  = next_idx(head_ff[deq_q]);
                        count_in[deq_q] = count_ff[deq_q] - 1'b1;
                        state_in        = S_DQ_HDR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_COPY: begin
            if (idx_ff != stg_len_ff) begin
               pay_rd_en      = 1'b1;
               pay_rd_addr    = PW'(STG_BASE) + PW'(idx_ff);
               idx_in         = idx_ff + 1'b1;
               copy_wr_in     = 1'b1;
               copy_wr_idx_in = idx_ff;
            end else begin
               state_in = S_VERD;
            end
         end
         S_VERD: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = KIND_VERDICT;
               rsp_last_in         = 1'b1;
               rsp_data_in         = '0;
               rsp_data_in.verdict = verdict_ff;
               state_in            = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EMPTY;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               state_in     = S_IDLE;
            end
         end
         S_DQ_HDR: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_kind_in              = KIND_HDR;
               rsp_last_in              = 1'b0;
               rsp_data_in              = '0;
               rsp_data_in.out_time     = hdr_rd_data.arrival_time;
               rsp_data_in.out_dest     = hdr_rd_data.dest_addr;
               rsp_data_in.out_src      = hdr_rd_data.src_addr;
               rsp_data_in.out_priority = hdr_rd_data.priority_req;
               rsp_data_in.out_len      = hdr_rd_data.payload_len;
               len_in                   = hdr_rd_data.payload_len;
               chk_in                   = hdr_rd_data.check_byte;
               if (hdr_rd_data.payload_len != '0) begin
                  pay_rd_en   = 1'b1;
                  pay_rd_addr = base_ff;
                  idx_in      = LEN_W'(1);
                  state_in    = S_DQ_BYTE;
               end else begin
                  state_in = S_DQ_TRL;
               end
            end
         end
         S_DQ_BYTE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_kind_in          = KIND_DATA;
               rsp_last_in          = 1'b0;
               rsp_data_in          = '0;
               rsp_data_in.out_byte = pay_rd_data;
               if (idx_ff != len_ff) begin
                  pay_rd_en = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  state_in = S_DQ_TRL;
               end
            end
         end
         S_DQ_TRL: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_kind_in          = KIND_TRL;
               rsp_last_in          = 1'b1;
               rsp_data_in          = '0;
               rsp_data_in.out_byte = chk_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '{default: '0};
         tail_ff       <= '{default: '0};
         count_ff      <= '{default: '0};
         assembling_ff <= 1'b0;
         xor_ff        <= '0;
         bytes_ff      <= '0;
         copy_wr_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         assembling_ff <= assembling_in;
         xor_ff        <= xor_in;
         bytes_ff      <= bytes_in;
         copy_wr_ff    <= copy_wr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_time_ff    <= stg_time_in;
      stg_dest_ff    <= stg_dest_in;
      stg_src_ff     <= stg_src_in;
      stg_prio_ff    <= stg_prio_in;
      stg_len_ff     <= stg_len_in;
      verdict_ff     <= verdict_in;
      base_ff        <= base_in;
      idx_ff         <= idx_in;
      len_ff         <= len_in;
      chk_ff         <= chk_in;
      copy_wr_idx_ff <= copy_wr_idx_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_data_ff    <= rsp_data_in;
   end

   ccpq_ram #(
      .WIDTH (HDR_W),
      .DEPTH (SLOTS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_wr_en),
      .wr_addr (hdr_wr_addr),
      .wr_data (hdr_wr_data),
      .rd_en   (hdr_rd_en),
      .rd_addr (hdr_rd_addr),
      .rd_data (hdr_rd_raw)
   );

   // queue slots first, staging area for the packet being assembled last
   ccpq_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PDEPTH)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (pay_wr_addr),
      .wr_data (pay_wr_data),
      .rd_en   (pay_rd_en),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hdl/ccpq_checker.sv
module ccpq_checker
   import ccpq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response word right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EMPTY || rsp_tuser == KIND_VERDICT
         || rsp_tuser == KIND_TRL) |-> rsp_tlast)
      else $error("single or closing word without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_HDR || rsp_tuser == KIND_DATA) |-> !rsp_tlast)
      else $error("packet word marked last before trailer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_HDR |-> rsp_tdata[60:0] == '0)
      else $error("header fields set on a non-header word");

endmodule

bind checksum_checked_priority_queues_top ccpq_checker u_ccpq_checker (.*);
